// ===== design/flow_template_set_parser_assert.svh =====
// ---------------------------------------------------------------------------
// flow template set parser assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ---------------------------------------------------------------------------
`ifndef FLOW_TEMPLATE_SET_PARSER_ASSERT_SVH
`define FLOW_TEMPLATE_SET_PARSER_ASSERT_SVH

// condition holds at every edge out of reset
`define FTSP_ASSERT_HOLDS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent holds on the edge after the antecedent
`define FTSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ftsp_pkg.sv =====
// ---------------------------------------------------------------------------
// ftsp_pkg
// shared types and codes of the flow template set parser
// ---------------------------------------------------------------------------
`default_nettype none

package ftsp_pkg;

    localparam int FTSP_FIFO_DEPTH = 8;
    localparam int FTSP_MAX_RESULTS = 3;

    localparam logic [1:0] FTSP_PHASE_HEADER = 2'd0;
    localparam logic [1:0] FTSP_PHASE_SPEC   = 2'd1;
    localparam logic [1:0] FTSP_PHASE_PEN    = 2'd2;

    localparam logic [2:0] FTSP_EV_START = 3'd0;
    localparam logic [2:0] FTSP_EV_FIELD = 3'd1;
    localparam logic [2:0] FTSP_EV_END   = 3'd2;
    localparam logic [2:0] FTSP_EV_DONE  = 3'd3;
    localparam logic [2:0] FTSP_EV_TRUNC = 3'd4;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] tmpl_id;
        logic [15:0] num_fields;
        logic        enterprise_flag;
        logic [14:0] element_id;
        logic [15:0] element_length;
        logic [31:0] ent_number;
        logic        scope_flag;
        logic        run_last;
    } ftsp_result_t;

    typedef struct packed {
        logic [1:0]                              count;
        ftsp_result_t [FTSP_MAX_RESULTS-1:0]     entry;
    } ftsp_push_t;

endpackage

`default_nettype wire

// ===== design/ftsp_parser.sv =====
// ---------------------------------------------------------------------------
// ftsp_parser
// byte-wise record header and field specifier parser, up to three results
// per accepted byte
// ---------------------------------------------------------------------------
`default_nettype none

module ftsp_parser
    import ftsp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       options_set,
    input  wire logic       set_last,
    output ftsp_push_t      push
);

    logic [1:0]  phase_reg,     phase_next;
    logic [2:0]  pos_reg,       pos_next;
    logic [63:0] asm_reg,       asm_next;
    logic [15:0] frem_reg,      frem_next;
    logic [15:0] fidx_reg,      fidx_next;
    logic [15:0] scope_reg,     scope_next;
    logic [15:0] tmpl_reg,      tmpl_next;
    logic        opt_reg,       opt_next;
    logic        started_reg,   started_next;

    logic        in_fire;
    logic        opt;
    logic [63:0] asm_cur;
    logic [3:0]  pos;
    logic [15:0] hdr_tmpl;
    logic [15:0] hdr_frem;
    logic [15:0] frem_dec;
    logic [15:0] tmpl_upd;
    logic        fld_v;
    logic [15:0] fld_raw;
    logic [15:0] fld_len;
    logic [31:0] fld_pen;
    logic        a_v;
    logic        b_v;
    logic        done_v;
    ftsp_result_t a_res;
    ftsp_result_t b_res;
    ftsp_result_t done_res;
    logic [1:0]  n;

    function automatic ftsp_result_t make_res(
        input logic [2:0]  ev,
        input logic [15:0] tid,
        input logic [15:0] cnt,
        input logic        ent,
        input logic [14:0] eid,
        input logic [15:0] len,
        input logic [31:0] pen,
        input logic        scope
    );
        ftsp_result_t r;
        r.event_res         = ev;
        r.tmpl_id           = tid;
        r.num_fields        = cnt;
        r.enterprise_flag   = ent;
        r.element_id        = eid;
        r.element_length    = len;
        r.ent_number        = pen;
        r.scope_flag        = scope;
        r.run_last          = 1'b0;
        return r;
    endfunction

    assign in_fire  = in_valid & in_ready;
    assign opt      = started_reg ? opt_reg : options_set;
    assign asm_cur  = {asm_reg[55:0], data_byte};
    assign pos      = {1'b0, pos_reg} + 4'd1;
    assign hdr_tmpl = opt ? asm_cur[47:32] : asm_cur[31:16];
    assign hdr_frem = opt ? asm_cur[31:16] : asm_cur[15:0];
    assign frem_dec = frem_reg - 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        asm_next     = asm_reg;
        frem_next    = frem_reg;
        fidx_next    = fidx_reg;
        scope_next   = scope_reg;
        tmpl_next    = tmpl_reg;
        opt_next     = opt_reg;
        started_next = started_reg;
        tmpl_upd     = tmpl_reg;
        fld_v        = 1'b0;
        fld_raw      = asm_cur[31:16];
        fld_len      = asm_cur[15:0];
        fld_pen      = '0;
        a_v          = 1'b0;
        b_v          = 1'b0;
        done_v       = 1'b0;
        a_res        = '0;
        b_res        = '0;
        done_res     = make_res(FTSP_EV_DONE, '0, '0, 1'b0, '0, '0, '0, 1'b0);

        if (in_fire) begin
            opt_next     = opt;
            started_next = 1'b1;
            asm_next     = asm_cur;
            pos_next     = pos[2:0];
            case (phase_reg)
                FTSP_PHASE_HEADER: begin
                    if (pos >= (opt ? 4'd6 : 4'd4)) begin
                        tmpl_upd   = hdr_tmpl;
                        tmpl_next  = hdr_tmpl;
                        frem_next  = hdr_frem;
                        scope_next = opt ? asm_cur[15:0] : 16'd0;
                        fidx_next  = '0;
                        pos_next   = '0;
                        asm_next   = '0;
                        a_v        = 1'b1;
                        a_res      = make_res(FTSP_EV_START, hdr_tmpl, hdr_frem,
                                              1'b0, '0, '0, '0, 1'b0);
                        if (hdr_frem == 16'd0) begin
                            b_v   = 1'b1;
                            b_res = make_res(FTSP_EV_END, hdr_tmpl, '0,
                                             1'b0, '0, '0, '0, 1'b0);
                        end else begin
                            phase_next = FTSP_PHASE_SPEC;
                        end
                    end
                end
                FTSP_PHASE_SPEC: begin
                    if (pos >= 4'd4) begin
                        if (asm_cur[31]) begin
                            phase_next = FTSP_PHASE_PEN;
                        end else begin
                            fld_v = 1'b1;
                        end
                    end
                end
                FTSP_PHASE_PEN: begin
                    if (pos >= 4'd8) begin
                        fld_v   = 1'b1;
                        fld_raw = asm_cur[63:48];
                        fld_len = asm_cur[47:32];
                        fld_pen = asm_cur[31:0];
                    end
                end
                default: begin
                    phase_next = FTSP_PHASE_HEADER;
                end
            endcase

            if (fld_v) begin
                a_v        = 1'b1;
                a_res      = make_res(FTSP_EV_FIELD, tmpl_reg, '0, fld_raw[15],
                                      fld_raw[14:0], fld_len,
                                      fld_raw[15] ? fld_pen : 32'd0,
                                      fidx_reg < scope_reg);
                fidx_next  = fidx_reg + 16'd1;
                frem_next  = frem_dec;
                phase_next = FTSP_PHASE_SPEC;
                pos_next   = '0;
                asm_next   = '0;
                if (frem_dec == 16'd0) begin
                    b_v        = 1'b1;
                    b_res      = make_res(FTSP_EV_END, tmpl_reg, '0,
                                          1'b0, '0, '0, '0, 1'b0);
                    phase_next = FTSP_PHASE_HEADER;
                end
            end

            if (set_last) begin
                if (phase_next != FTSP_PHASE_HEADER) begin
                    b_v   = 1'b1;
                    b_res = make_res(FTSP_EV_TRUNC, tmpl_upd, '0,
                                     1'b0, '0, '0, '0, 1'b0);
                end
                done_v       = 1'b1;
                phase_next   = FTSP_PHASE_HEADER;
                pos_next     = '0;
                asm_next     = '0;
                frem_next    = '0;
                fidx_next    = '0;
                scope_next   = '0;
                tmpl_next    = '0;
                opt_next     = 1'b0;
                started_next = 1'b0;
            end
        end
    end

    // pack results in order, flag the last one
    always_comb begin
        push = '0;
        n    = '0;
        if (a_v) begin
            push.entry[n] = a_res;
            n             = n + 2'd1;
        end
        if (b_v) begin
            push.entry[n] = b_res;
            n             = n + 2'd1;
        end
        if (done_v) begin
            push.entry[n] = done_res;
            n             = n + 2'd1;
        end
        if (n != 2'd0) begin
            push.entry[n - 2'd1].run_last = 1'b1;
        end
        push.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= FTSP_PHASE_HEADER;
            pos_reg     <= '0;
            asm_reg     <= '0;
            frem_reg    <= '0;
            fidx_reg    <= '0;
            scope_reg   <= '0;
            tmpl_reg    <= '0;
            opt_reg     <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            asm_reg     <= asm_next;
            frem_reg    <= frem_next;
            fidx_reg    <= fidx_next;
            scope_reg   <= scope_next;
            tmpl_reg    <= tmpl_next;
            opt_reg     <= opt_next;
            started_reg <= started_next;
        end
    end

`include "flow_template_set_parser_assert.svh"

    `FTSP_ASSERT_NEXT(a_last_clears, aclk, aresetn, in_fire && set_last, phase_reg == FTSP_PHASE_HEADER && !started_reg && pos_reg == 3'd0, "set end did not clear parse state")
    `FTSP_ASSERT_HOLDS(a_mid_set, aclk, aresetn, (pos_reg == 3'd0 && phase_reg == FTSP_PHASE_HEADER) || started_reg, "parse progress outside a set")
    `FTSP_ASSERT_HOLDS(a_push_on_fire, aclk, aresetn, push.count == 2'd0 || in_fire, "results without an accepted word")

endmodule

`default_nettype wire

// ===== design/ftsp_result_fifo.sv =====
// ---------------------------------------------------------------------------
// ftsp_result_fifo
// result queue taking up to three words per cycle, giving one per cycle while out_ready is high
// ---------------------------------------------------------------------------
`default_nettype none

module ftsp_result_fifo
    import ftsp_pkg::*;
#(
    parameter int DEPTH = FTSP_FIFO_DEPTH
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ftsp_push_t  push,
    output logic             space,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ftsp_result_t     out_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;
    localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(DEPTH - FTSP_MAX_RESULTS);
    localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM   = SUM_W'(DEPTH);

    ftsp_result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_addr [FTSP_MAX_RESULTS];

    function automatic logic [PTR_W-1:0] ptr_add(
        input logic [PTR_W-1:0] p,
        input logic [1:0]       k
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(k);
        if (s >= DEPTH_SUM) begin
            s = s - DEPTH_SUM;
        end
        return s[PTR_W-1:0];
    endfunction

    assign space     = count_reg <= READY_LIMIT;
    assign out_valid = count_reg != '0;
    assign pop       = out_valid & out_ready;
    assign out_word  = mem[rd_ptr_reg];

    always_comb begin
        for (int i = 0; i < FTSP_MAX_RESULTS; i++) begin
            wr_addr[i] = ptr_add(wr_ptr_reg, 2'(i));
        end
        wr_ptr_next = ptr_add(wr_ptr_reg, push.count);
        rd_ptr_next = pop ? ptr_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FTSP_MAX_RESULTS; i++) begin
            if (2'(i) < push.count) begin
                mem[wr_addr[i]] <= push.entry[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "flow_template_set_parser_assert.svh"

    `FTSP_ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT, "result queue count beyond depth")
    `FTSP_ASSERT_HOLDS(a_push_room, aclk, aresetn, push.count == 2'd0 || count_reg <= READY_LIMIT, "push without room for a full group")
    `FTSP_ASSERT_NEXT(a_push_fills, aclk, aresetn, push.count != 2'd0 && !pop, count_reg != '0, "pushed words went missing")

endmodule

`default_nettype wire

// ===== design/flow_template_set_parser.sv =====
// ---------------------------------------------------------------------------
// flow_template_set_parser
// flow-export template set body parser emitting record and field events
// ---------------------------------------------------------------------------
// One byte of the set body is taken per cycle while the result queue has room
// for three words (count at most FIFO_DEPTH - 3); each byte yields zero to
// three event words, which appear on the m_ side from the cycle after the byte
// and, with m_ready high, leave at one word per cycle through the queue, so a
// byte stream whose bytes each cause at most one word runs at one byte per
// cycle; bursts of several words per byte are paced by the single output port.
`default_nettype none

module flow_template_set_parser
    import ftsp_pkg::*;
#(
    parameter int FIFO_DEPTH = FTSP_FIFO_DEPTH
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_options_set,
    input  wire logic        s_set_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [15:0]      m_tmpl_id,
    output logic [15:0]      m_num_fields,
    output logic             m_enterprise_flag,
    output logic [14:0]      m_element_id,
    output logic [15:0]      m_element_length,
    output logic [31:0]      m_ent_number,
    output logic             m_scope_flag,
    output logic             m_run_last
);

    ftsp_push_t   push;
    ftsp_result_t head;

    ftsp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .data_byte   (s_data_byte),
        .options_set (s_options_set),
        .set_last    (s_set_last),
        .push        (push)
    );

    ftsp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space     (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (head)
    );

    assign m_event_res         = head.event_res;
    assign m_tmpl_id           = head.tmpl_id;
    assign m_num_fields        = head.num_fields;
    assign m_enterprise_flag   = head.enterprise_flag;
    assign m_element_id        = head.element_id;
    assign m_element_length    = head.element_length;
    assign m_ent_number        = head.ent_number;
    assign m_scope_flag        = head.scope_flag;
    assign m_run_last          = head.run_last;

endmodule

`default_nettype wire

// ===== dv/ftsp_event_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ftsp_event_checker
// watches both channels of the flow template set parser, predicts the event
// words of every accepted byte and compares each result word in order
// ---------------------------------------------------------------------------

module ftsp_event_checker
    import ftsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_options_set,
    input  wire logic        s_set_last,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_event_res,
    input  wire logic [15:0] m_tmpl_id,
    input  wire logic [15:0] m_num_fields,
    input  wire logic        m_enterprise_flag,
    input  wire logic [14:0] m_element_id,
    input  wire logic [15:0] m_element_length,
    input  wire logic [31:0] m_ent_number,
    input  wire logic        m_scope_flag,
    input  wire logic        m_run_last,
    output int               fail_count,
    output int               outstanding
);

    ftsp_result_t expected_events[$];
    ftsp_result_t byte_events[$];
    ftsp_result_t want;

    logic [1:0]  phase;
    logic [2:0]  byte_pos;
    logic [63:0] shift_bytes;
    logic [15:0] fields_left;
    logic [15:0] field_idx;
    logic [15:0] scope_cnt;
    logic [15:0] cur_template;
    logic        opt_latched;
    logic        in_set;

    function automatic ftsp_result_t make_event(
        input logic [2:0]  ev,
        input logic [15:0] tid,
        input logic [15:0] cnt,
        input logic        ent,
        input logic [14:0] eid,
        input logic [15:0] len,
        input logic [31:0] pen,
        input logic        scope
    );
        ftsp_result_t w;
        w.event_res         = ev;
        w.tmpl_id           = tid;
        w.num_fields        = cnt;
        w.enterprise_flag   = ent;
        w.element_id        = eid;
        w.element_length    = len;
        w.ent_number        = pen;
        w.scope_flag        = scope;
        w.run_last          = 1'b0;
        return w;
    endfunction

    task automatic clear_parser();
        phase        = FTSP_PHASE_HEADER;
        byte_pos     = 3'd0;
        shift_bytes  = 64'd0;
        fields_left  = 16'd0;
        field_idx    = 16'd0;
        scope_cnt    = 16'd0;
        cur_template = 16'd0;
        opt_latched  = 1'b0;
        in_set       = 1'b0;
    endtask

    task automatic add_field(input logic [15:0] raw_id, input logic [15:0] len,
                             input logic [31:0] pen);
        logic ent;
        ent = raw_id[15];
        byte_events = {byte_events,
                       make_event(FTSP_EV_FIELD, cur_template, 16'd0, ent,
                                  raw_id[14:0], len, ent ? pen : 32'd0,
                                  field_idx < scope_cnt)};
        field_idx   = field_idx + 16'd1;
        fields_left = fields_left - 16'd1;
        phase       = FTSP_PHASE_SPEC;
        if (fields_left == 16'd0) begin
            byte_events = {byte_events,
                           make_event(FTSP_EV_END, cur_template, 16'd0, 1'b0,
                                      15'd0, 16'd0, 32'd0, 1'b0)};
            phase = FTSP_PHASE_HEADER;
        end
        byte_pos    = 3'd0;
        shift_bytes = 64'd0;
    endtask

    task automatic predict_byte(input logic [7:0] data, input logic opt, input logic last);
        int pos;
        byte_events.delete();
        if (!in_set) begin
            opt_latched = opt;
            in_set      = 1'b1;
        end
        shift_bytes = {shift_bytes[55:0], data};
        pos         = int'(byte_pos) + 1;
        byte_pos    = 3'(pos);
        case (phase)
            FTSP_PHASE_HEADER: begin
                if (pos >= (opt_latched ? 6 : 4)) begin
                    if (opt_latched) begin
                        cur_template = shift_bytes[47:32];
                        fields_left  = shift_bytes[31:16];
                        scope_cnt    = shift_bytes[15:0];
                    end else begin
                        cur_template = shift_bytes[31:16];
                        fields_left  = shift_bytes[15:0];
                        scope_cnt    = 16'd0;
                    end
                    field_idx   = 16'd0;
                    byte_pos    = 3'd0;
                    shift_bytes = 64'd0;
                    byte_events = {byte_events,
                                   make_event(FTSP_EV_START, cur_template, fields_left,
                                              1'b0, 15'd0, 16'd0, 32'd0, 1'b0)};
                    if (fields_left == 16'd0) begin
                        byte_events = {byte_events,
                                       make_event(FTSP_EV_END, cur_template, 16'd0,
                                                  1'b0, 15'd0, 16'd0, 32'd0, 1'b0)};
                    end else begin
                        phase = FTSP_PHASE_SPEC;
                    end
                end
            end
            FTSP_PHASE_SPEC: begin
                if (pos >= 4) begin
                    if (shift_bytes[31]) begin
                        phase = FTSP_PHASE_PEN;
                    end else begin
                        add_field(shift_bytes[31:16], shift_bytes[15:0], 32'd0);
                    end
                end
            end
            FTSP_PHASE_PEN: begin
                if (pos >= 8) begin
                    add_field(shift_bytes[63:48], shift_bytes[47:32], shift_bytes[31:0]);
                end
            end
            default: ;
        endcase
        if (last) begin
            // set closed with a record still open
            if (phase != FTSP_PHASE_HEADER) begin
                byte_events = {byte_events,
                               make_event(FTSP_EV_TRUNC, cur_template, 16'd0, 1'b0,
                                          15'd0, 16'd0, 32'd0, 1'b0)};
            end
            byte_events = {byte_events,
                           make_event(FTSP_EV_DONE, 16'd0, 16'd0, 1'b0, 15'd0,
                                      16'd0, 32'd0, 1'b0)};
            clear_parser();
        end
        if (byte_events.size() > 0) begin
            byte_events[byte_events.size() - 1].run_last = 1'b1;
        end
        foreach (byte_events[i]) begin
            expected_events = {expected_events, byte_events[i]};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            expected_events.delete();
            fail_count  = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result word: event_res 0x%0h", m_event_res);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(m_event_res));
                    check_field("tmpl_id", 32'(want.tmpl_id), 32'(m_tmpl_id));
                    check_field("num_fields", 32'(want.num_fields), 32'(m_num_fields));
                    check_field("enterprise_flag", 32'(want.enterprise_flag),
                                32'(m_enterprise_flag));
                    check_field("element_id", 32'(want.element_id), 32'(m_element_id));
                    check_field("element_length", 32'(want.element_length),
                                32'(m_element_length));
                    check_field("ent_number", want.ent_number, m_ent_number);
                    check_field("scope_flag", 32'(want.scope_flag), 32'(m_scope_flag));
                    check_field("run_last", 32'(want.run_last), 32'(m_run_last));
                end
            end
            if (s_valid && s_ready) begin
                predict_byte(s_data_byte, s_options_set, s_set_last);
            end
            outstanding <= expected_events.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives template set bodies into the flow template set parser byte by byte,
// directed corner sets first and then random sets with idle gaps and stalls
// ---------------------------------------------------------------------------

module testbench;
    import ftsp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_options_set;
    logic        s_set_last;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_res;
    logic [15:0] m_tmpl_id;
    logic [15:0] m_num_fields;
    logic        m_enterprise_flag;
    logic [14:0] m_element_id;
    logic [15:0] m_element_length;
    logic [31:0] m_ent_number;
    logic        m_scope_flag;
    logic        m_run_last;

    int          fail_count;
    int          outstanding;

    logic [7:0]  set_bytes[$];
    logic        set_opt;
    int          tx_mode;
    int          rx_mode;
    int          bytes_sent;
    int          hold_requests;
    int          holds_done;
    int          set_no;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    flow_template_set_parser u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_options_set       (s_options_set),
        .s_set_last          (s_set_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_res         (m_event_res),
        .m_tmpl_id           (m_tmpl_id),
        .m_num_fields        (m_num_fields),
        .m_enterprise_flag   (m_enterprise_flag),
        .m_element_id        (m_element_id),
        .m_element_length    (m_element_length),
        .m_ent_number        (m_ent_number),
        .m_scope_flag        (m_scope_flag),
        .m_run_last          (m_run_last)
    );

    ftsp_event_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_options_set       (s_options_set),
        .s_set_last          (s_set_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_event_res         (m_event_res),
        .m_tmpl_id           (m_tmpl_id),
        .m_num_fields        (m_num_fields),
        .m_enterprise_flag   (m_enterprise_flag),
        .m_element_id        (m_element_id),
        .m_element_length    (m_element_length),
        .m_ent_number        (m_ent_number),
        .m_scope_flag        (m_scope_flag),
        .m_run_last          (m_run_last),
        .fail_count          (fail_count),
        .outstanding         (outstanding)
    );

    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 17)) : 0;
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            3:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push16(input logic [15:0] v);
        set_bytes = {set_bytes, v[15:8]};
        set_bytes = {set_bytes, v[7:0]};
    endtask

    task automatic build_random_set(input bit force_clean);
        int          n_rec;
        int          n_fld;
        int          style;
        logic [15:0] raw_id;
        set_bytes.delete();
        set_opt = 1'($urandom);
        n_rec   = force_clean ? 3 : $urandom_range(0, 3);
        style   = force_clean ? 0 : $urandom_range(0, 19);
        if (style == 19) begin
            // noise
            repeat ($urandom_range(1, 24)) set_bytes = {set_bytes, 8'($urandom)};
        end else begin
            repeat (n_rec) begin
                n_fld = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
                push16(pick16());
                push16(($urandom_range(0, 9) == 0) ? pick16() : 16'(n_fld));
                if (set_opt) begin
                    push16(($urandom_range(0, 9) == 0) ? pick16()
                                                      : 16'($urandom_range(0, n_fld + 1)));
                end
                repeat (n_fld) begin
                    raw_id = 16'($urandom);
                    push16(raw_id);
                    push16(pick16());
                    if (raw_id[15]) begin
                        push16(16'($urandom));
                        push16(16'($urandom));
                    end
                end
            end
            if (style >= 13 && style <= 15) begin
                // cut short by dropping up to seven trailing bytes
                repeat ($urandom_range(1, 7)) begin
                    if (set_bytes.size() > 1) void'(set_bytes.pop_back());
                end
            end else if (style >= 16) begin
                // trailing partial header
                repeat ($urandom_range(1, set_opt ? 5 : 3)) set_bytes = {set_bytes, 8'($urandom)};
            end
        end
        if (set_bytes.size() == 0) set_bytes = {set_bytes, 8'($urandom)};
    endtask

    task automatic send_set();
        int gap;
        foreach (set_bytes[i]) begin
            gap = draw_gap(tx_mode);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid       <= 1'b1;
            s_data_byte   <= set_bytes[i];
            s_options_set <= (i == 0) ? set_opt : 1'($urandom);
            s_set_last    <= (i == set_bytes.size() - 1);
            do @(posedge aclk); while (!s_ready);
            bytes_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data_byte   <= 8'd0;
        s_options_set <= 1'b0;
        s_set_last    <= 1'b0;
        bytes_sent    = 0;
        hold_requests = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty record, then a record whose only field is enterprise with all ones
        tx_mode   = 0;
        set_opt   = 1'b0;
        set_bytes = {8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                     8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_set();
        // options set with a scope field, closed while a field is still owed
        tx_mode   = 2;
        set_opt   = 1'b1;
        set_bytes = {8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00, 8'h0a, 8'h00, 8'h04};
        send_set();
        // lone byte of padding
        tx_mode   = 1;
        set_opt   = 1'b0;
        set_bytes = {8'h00};
        send_set();
        wait_drained();

        set_no = 0;
        while (bytes_sent < 320) begin
            tx_mode = $urandom_range(0, 2);
            if (set_no == 2) begin
                hold_requests++;
                tx_mode = 0;
            end
            build_random_set(set_no == 2);
            send_set();
            if (set_no % 6 == 5) wait_drained();
            set_no++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int stall;
        int words_in_mode;
        holds_done    = 0;
        words_in_mode = 0;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (holds_done < hold_requests) begin
                // long back-pressure so the result queue fills and the input stalls
                holds_done++;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
            end
            if (words_in_mode == 0) begin
                rx_mode       = $urandom_range(0, 2);
                words_in_mode = $urandom_range(8, 40);
            end
            words_in_mode--;
            stall = draw_gap(rx_mode);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== flow_template_set_parser.f =====
+incdir+design
design/ftsp_pkg.sv
design/ftsp_parser.sv
design/ftsp_result_fifo.sv
design/flow_template_set_parser.sv
dv/ftsp_event_checker.sv
dv/testbench.sv
